FILE: src/lfsh_pkg.sv
// ============================================================================
// lfsh_pkg
// Types and constants shared by the length-filtered symbol histogram.
// ============================================================================
package lfsh_pkg;

    localparam int SYMBOL_W       = 7;
    localparam int SYM_CMP_W      = SYMBOL_W + 2;
    localparam int OP_W           = 2;
    localparam int CFG_DATA_W     = 40;
    localparam int CFG_INDEX_W    = 1;
    localparam int READ_TOTAL_W   = 40;
    localparam int BASE_TOTAL_W   = 48;
    localparam int SYMBOL_TOTAL_W = 48;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;

    localparam logic [OP_W-1:0] OP_SYMBOL = 2'd0;
    localparam logic [OP_W-1:0] OP_END    = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN = 1'd1;

    typedef enum logic [1:0] {
        JOB_SYMBOL,
        JOB_END,
        JOB_QUERY
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [SYMBOL_W-1:0] symbol;
        logic                in_range;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM,
        ST_WALK,
        ST_QUERY,
        ST_RESP
    } state_t;

endpackage

FILE: src/lfsh_if.sv
// ============================================================================
// lfsh_in_if / lfsh_out_if
// Request and result channels of the length-filtered symbol histogram.
// ============================================================================
interface lfsh_in_if
    import lfsh_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SYMBOL_W-1:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface lfsh_out_if
    import lfsh_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [READ_TOTAL_W-1:0]   read_total;
    logic [BASE_TOTAL_W-1:0]   base_total;
    logic [SYMBOL_TOTAL_W-1:0] symbol_total;

    modport source (output valid, output accepted, output read_total,
                    output base_total, output symbol_total, input ready);
    modport sink   (input valid, input accepted, input read_total,
                    input base_total, input symbol_total, output ready);
endinterface

FILE: src/lfsh_front.sv
// ============================================================================
// lfsh_front
// Accepts requests, decodes the operation and checks the symbol range.
// ============================================================================
module lfsh_front
    import lfsh_pkg::*;
#(
    parameter int NUM_SYMBOLS = 128
)
(
    lfsh_in_if.sink item,
    input  logic    queue_not_full,
    output logic    push,
    output job_t    job
);

    localparam logic [SYM_CMP_W-1:0] SYM_LIMIT = SYM_CMP_W'(NUM_SYMBOLS);

    logic known_op;

    assign item.ready = queue_not_full;

    always_comb
    begin
        job.symbol   = item.symbol;
        job.in_range = ({2'b00, item.symbol} < SYM_LIMIT);
        job.kind     = JOB_SYMBOL;
        known_op     = 1'b1;
        unique case (item.op)
            OP_SYMBOL: job.kind = JOB_SYMBOL;
            OP_END:    job.kind = JOB_END;
            OP_QUERY:  job.kind = JOB_QUERY;
            default:   known_op = 1'b0;
        endcase
    end

    assign push = item.valid && queue_not_full && known_op;

endmodule

FILE: src/lfsh_queue.sv
// ============================================================================
// lfsh_queue
// Short first-in first-out queue of decoded requests.
// ============================================================================
module lfsh_queue
    import lfsh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic not_empty,
    output logic not_full
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/lfsh_back.sv
// ============================================================================
// lfsh_back
// Executes requests against the pending and committed histograms.
// ============================================================================
module lfsh_back
    import lfsh_pkg::*;
#(
    parameter int NUM_SYMBOLS  = 128,
    parameter int TOTAL_WIDTH  = 48,
    parameter int LENGTH_WIDTH = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  job_t                          job,
    input  logic                          job_valid,
    output logic                          pop,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    lfsh_out_if.source                    result
);

    localparam int IW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CW = $clog2(NUM_SYMBOLS + 1);
    localparam int SW = ((TOTAL_WIDTH > LENGTH_WIDTH) ? TOTAL_WIDTH : LENGTH_WIDTH) + 1;
    localparam logic [CW-1:0]           WALK_END  = CW'(NUM_SYMBOLS);
    localparam logic [SW-1:0]           TOTAL_TOP = SW'({TOTAL_WIDTH{1'b1}});
    localparam logic [LENGTH_WIDTH-1:0] LEN_TOP   = {LENGTH_WIDTH{1'b1}};

    state_t                  state_reg;
    state_t                  state_next;
    logic [CW-1:0]           walk_cnt_reg;
    logic [CW-1:0]           walk_cnt_next;
    logic                    wr_pend_reg;
    logic [IW-1:0]           wr_idx_reg;
    logic [IW-1:0]           sym_idx_reg;
    logic                    in_range_reg;

    logic [LENGTH_WIDTH-1:0] pend_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]  pend_vld_reg;
    logic [LENGTH_WIDTH-1:0] pend_rd_reg;
    logic                    pend_rd_vld_reg;
    logic [TOTAL_WIDTH-1:0]  comm_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]  comm_vld_reg;
    logic [TOTAL_WIDTH-1:0]  comm_rd_reg;
    logic                    comm_rd_vld_reg;

    logic [LENGTH_WIDTH-1:0] len_reg;
    logic [LENGTH_WIDTH-1:0] reads_reg;
    logic [TOTAL_WIDTH-1:0]  bases_reg;
    logic [LENGTH_WIDTH-1:0] min_reg;
    logic [LENGTH_WIDTH-1:0] max_reg;

    logic                    resp_acc_reg;
    logic [TOTAL_WIDTH-1:0]  resp_sym_reg;
    logic                    out_valid_reg;
    logic                    out_acc_reg;
    logic [READ_TOTAL_W-1:0] out_reads_reg;
    logic [BASE_TOTAL_W-1:0] out_bases_reg;
    logic [SYMBOL_TOTAL_W-1:0] out_sym_reg;

    logic                    pass;
    logic                    walk_issue;
    logic                    walk_done;
    logic                    out_free;
    logic                    pend_rd_en;
    logic [IW-1:0]           pend_rd_addr;
    logic                    pend_we;
    logic [LENGTH_WIDTH-1:0] pend_eff;
    logic [LENGTH_WIDTH-1:0] pend_wr_data;
    logic                    comm_rd_en;
    logic [IW-1:0]           comm_rd_addr;
    logic                    comm_we;
    logic [TOTAL_WIDTH-1:0]  comm_eff;
    logic [SW-1:0]           comm_sum;
    logic [TOTAL_WIDTH-1:0]  comm_wr_data;
    logic [SW-1:0]           bases_sum;
    logic                    len_inc;
    logic                    finish_end;
    logic                    commit;
    logic                    query_cap;
    logic                    out_load;

    assign pass       = (len_reg >= min_reg) && (len_reg <= max_reg);
    assign walk_issue = (walk_cnt_reg != WALK_END);
    assign walk_done  = (walk_cnt_reg == WALK_END);
    assign out_free   = !out_valid_reg || result.ready;

    assign pend_eff     = pend_rd_vld_reg ? pend_rd_reg : '0;
    assign pend_wr_data = (pend_eff == LEN_TOP) ? pend_eff : pend_eff + 1'b1;
    assign comm_eff     = comm_rd_vld_reg ? comm_rd_reg : '0;
    assign comm_sum     = SW'(comm_eff) + SW'(pend_eff);
    assign comm_wr_data = (comm_sum > TOTAL_TOP) ? {TOTAL_WIDTH{1'b1}}
                                                 : comm_sum[TOTAL_WIDTH-1:0];
    assign bases_sum    = SW'(bases_reg) + SW'(len_reg);

    always_comb
    begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                walk_cnt_next = '0;
                if (job_valid)
                begin
                    unique case (job.kind)
                        JOB_SYMBOL: state_next = job.in_range ? ST_SYM : ST_IDLE;
                        JOB_END:    state_next = pass ? ST_WALK : ST_RESP;
                        JOB_QUERY:  state_next = ST_QUERY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SYM:   state_next = ST_IDLE;
            ST_WALK:
            begin
                if (walk_issue)
                begin
                    walk_cnt_next = walk_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_QUERY: state_next = ST_RESP;
            ST_RESP:  state_next = out_free ? ST_IDLE : ST_RESP;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        pend_rd_en   = 1'b0;
        pend_rd_addr = IW'(job.symbol);
        pend_we      = 1'b0;
        comm_rd_en   = 1'b0;
        comm_rd_addr = IW'(job.symbol);
        comm_we      = 1'b0;
        len_inc      = 1'b0;
        finish_end   = 1'b0;
        commit       = 1'b0;
        query_cap    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    unique case (job.kind)
                        JOB_SYMBOL:
                        begin
                            len_inc    = 1'b1;
                            pend_rd_en = job.in_range;
                        end
                        JOB_END:    finish_end = !pass;
                        JOB_QUERY:  comm_rd_en = 1'b1;
                        default:    pop = 1'b1;
                    endcase
                end
            end
            ST_SYM:   pend_we = 1'b1;
            ST_WALK:
            begin
                pend_rd_en   = walk_issue;
                comm_rd_en   = walk_issue;
                pend_rd_addr = walk_cnt_reg[IW-1:0];
                comm_rd_addr = walk_cnt_reg[IW-1:0];
                comm_we      = wr_pend_reg;
                finish_end   = walk_done;
                commit       = walk_done;
            end
            ST_QUERY: query_cap = 1'b1;
            ST_RESP:  out_load = out_free;
            default:  pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            walk_cnt_reg    <= '0;
            wr_pend_reg     <= 1'b0;
            pend_vld_reg    <= '0;
            pend_rd_vld_reg <= 1'b0;
            comm_vld_reg    <= '0;
            comm_rd_vld_reg <= 1'b0;
            len_reg         <= '0;
            reads_reg       <= '0;
            bases_reg       <= '0;
            min_reg         <= '0;
            max_reg         <= LEN_TOP;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;
            wr_pend_reg  <= (state_reg == ST_WALK) && walk_issue;

            if (pend_rd_en)
            begin
                pend_rd_vld_reg <= pend_vld_reg[pend_rd_addr];
            end
            if (comm_rd_en)
            begin
                comm_rd_vld_reg <= comm_vld_reg[comm_rd_addr];
            end

            if (finish_end)
            begin
                pend_vld_reg <= '0;
            end
            else if (pend_we)
            begin
                pend_vld_reg[sym_idx_reg] <= 1'b1;
            end
            if (comm_we)
            begin
                comm_vld_reg[wr_idx_reg] <= 1'b1;
            end

            if (finish_end)
            begin
                len_reg <= '0;
            end
            else if (len_inc && (len_reg != LEN_TOP))
            begin
                len_reg <= len_reg + 1'b1;
            end

            if (commit)
            begin
                if (reads_reg != LEN_TOP)
                begin
                    reads_reg <= reads_reg + 1'b1;
                end
                bases_reg <= (bases_sum > TOTAL_TOP) ? {TOTAL_WIDTH{1'b1}}
                                                     : bases_sum[TOTAL_WIDTH-1:0];
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_LEN: min_reg <= LENGTH_WIDTH'(cfg_data);
                    CFG_MAX_LEN: max_reg <= LENGTH_WIDTH'(cfg_data);
                    default:     min_reg <= min_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[sym_idx_reg] <= pend_wr_data;
        end
        if (pend_rd_en)
        begin
            pend_rd_reg <= pend_mem[pend_rd_addr];
        end
        if (comm_we)
        begin
            comm_mem[wr_idx_reg] <= comm_wr_data;
        end
        if (comm_rd_en)
        begin
            comm_rd_reg <= comm_mem[comm_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg <= walk_cnt_reg[IW-1:0];
        if (pop)
        begin
            sym_idx_reg  <= IW'(job.symbol);
            in_range_reg <= job.in_range;
        end
        if (finish_end)
        begin
            resp_acc_reg <= commit;
            resp_sym_reg <= '0;
        end
        else if (query_cap)
        begin
            resp_acc_reg <= 1'b0;
            resp_sym_reg <= in_range_reg ? comm_eff : '0;
        end
        if (out_load)
        begin
            out_acc_reg   <= resp_acc_reg;
            out_reads_reg <= READ_TOTAL_W'(reads_reg);
            out_bases_reg <= BASE_TOTAL_W'(bases_reg);
            out_sym_reg   <= SYMBOL_TOTAL_W'(resp_sym_reg);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_acc_reg;
    assign result.read_total   = out_reads_reg;
    assign result.base_total   = out_bases_reg;
    assign result.symbol_total = out_sym_reg;

endmodule

FILE: src/length_filtered_symbol_histogram.sv
// ============================================================================
// length_filtered_symbol_histogram
// Symbol histogram of sequence reads, counting only reads of accepted length.
// ============================================================================
// Requests arrive on item: op selects a symbol of the current read, the end
// of the read, or a query of one symbol's committed count. End of read and
// query each give one result on result; symbols give none.
// The front decodes each request into a four-entry queue, so the input keeps
// flowing while the back is busy. In the back a symbol's pending count is
// read and then written in ST_SYM through one memory port. A query reads the
// committed count and captures it in ST_QUERY; a failing end of read goes
// straight to ST_RESP. A passing end of read walks the pending memory one
// entry a cycle, adding each count into the committed memory.
// The result is held in an output register; while the receiver stalls the
// back finishes the next request and then waits, and the queue fills.
// Configuration (min_len, max_len) is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while idle, as the block itself does
// not enforce it. Reset clears all counts and totals at once through
// per-entry valid bits, and min_len and max_len return to zero and all ones.
// ============================================================================
module length_filtered_symbol_histogram
    import lfsh_pkg::*;
#(
    parameter int NUM_SYMBOLS  = 128,
    parameter int TOTAL_WIDTH  = 48,
    parameter int LENGTH_WIDTH = 40
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    lfsh_in_if.sink                item,
    lfsh_out_if.source             result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic not_empty;
    logic not_full;

    lfsh_front #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .item           (item),
        .queue_not_full (not_full),
        .push           (push),
        .job            (push_job)
    );

    lfsh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    lfsh_back #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .TOTAL_WIDTH  (TOTAL_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head),
        .job_valid (not_empty),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

FILE: sim/histogram_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// histogram_checker
// Predicts and checks the results of the length-filtered symbol histogram.
// ============================================================================
// Watches the request and result channels and the register write port. Every
// accepted symbol or end of read updates a private copy of the committed and
// pending histograms, the read length and the totals, and end of read or query
// pushes the result it must produce. Each accepted result is compared field
// by field with the oldest one waiting. The mismatch count and the number of
// results still awaited are handed to the test top.
// ============================================================================
module histogram_checker
    import lfsh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    lfsh_in_if                     item,
    lfsh_out_if                    result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     failures,
    output int                     outstanding
);

    localparam int NUM_SYMBOLS = 128;
    localparam logic [BASE_TOTAL_W-1:0] BASE_TOP   = '1;
    localparam logic [BASE_TOTAL_W-1:0] LENGTH_TOP = BASE_TOTAL_W'({CFG_DATA_W{1'b1}});

    typedef struct packed {
        logic                      accepted;
        logic [READ_TOTAL_W-1:0]   read_total;
        logic [BASE_TOTAL_W-1:0]   base_total;
        logic [SYMBOL_TOTAL_W-1:0] symbol_total;
    } tally_t;

    logic [BASE_TOTAL_W-1:0] committed_hist [NUM_SYMBOLS];
    logic [CFG_DATA_W-1:0]   pending_hist [NUM_SYMBOLS];
    logic [CFG_DATA_W-1:0]   read_length;
    logic [CFG_DATA_W-1:0]   read_count;
    logic [BASE_TOTAL_W-1:0] base_count;
    logic [CFG_DATA_W-1:0]   min_length;
    logic [CFG_DATA_W-1:0]   max_length;
    tally_t                  expected_tallies [$];
    tally_t                  oldest;

    function automatic logic [BASE_TOTAL_W-1:0] capped_sum(
        input logic [BASE_TOTAL_W-1:0] a,
        input logic [BASE_TOTAL_W-1:0] b,
        input logic [BASE_TOTAL_W-1:0] top
    );
        logic [BASE_TOTAL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, top}) ? top : sum[BASE_TOTAL_W-1:0];
    endfunction

    task automatic apply_request(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] symbol);
        tally_t tally;
        tally = '0;
        case (op)
            OP_SYMBOL:
            begin
                read_length = CFG_DATA_W'(capped_sum(BASE_TOTAL_W'(read_length), 1, LENGTH_TOP));
                pending_hist[symbol] =
                    CFG_DATA_W'(capped_sum(BASE_TOTAL_W'(pending_hist[symbol]), 1, LENGTH_TOP));
            end
            OP_END:
            begin
                if (read_length >= min_length && read_length <= max_length)
                begin
                    tally.accepted = 1'b1;
                    for (int i = 0; i < NUM_SYMBOLS; i++)
                    begin
                        committed_hist[i] = capped_sum(committed_hist[i],
                                                       BASE_TOTAL_W'(pending_hist[i]), BASE_TOP);
                    end
                    read_count = CFG_DATA_W'(capped_sum(BASE_TOTAL_W'(read_count), 1, LENGTH_TOP));
                    base_count = capped_sum(base_count, BASE_TOTAL_W'(read_length), BASE_TOP);
                end
                for (int i = 0; i < NUM_SYMBOLS; i++)
                begin
                    pending_hist[i] = '0;
                end
                read_length = '0;
                tally.read_total = read_count;
                tally.base_total = base_count;
                expected_tallies.push_back(tally);
            end
            OP_QUERY:
            begin
                tally.read_total   = read_count;
                tally.base_total   = base_count;
                tally.symbol_total = committed_hist[symbol];
                expected_tallies.push_back(tally);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SYMBOLS; i++)
            begin
                committed_hist[i] = '0;
                pending_hist[i]   = '0;
            end
            read_length = '0;
            read_count  = '0;
            base_count  = '0;
            min_length  = '0;
            max_length  = '1;
            expected_tallies.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_LEN)
                begin
                    min_length = cfg_data;
                end
                else if (cfg_index == CFG_MAX_LEN)
                begin
                    max_length = cfg_data;
                end
            end
            if (result.valid && result.ready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    failures++;
                    $display("%0t: expected no result, got accepted %0d read_total %0d %s %0d %s %0d",
                             $time, result.accepted, result.read_total, "base_total",
                             result.base_total, "symbol_total", result.symbol_total);
                end
                else
                begin
                    oldest = expected_tallies.pop_front();
                    check_field("accepted", 64'(oldest.accepted), 64'(result.accepted));
                    check_field("read_total", 64'(oldest.read_total), 64'(result.read_total));
                    check_field("base_total", 64'(oldest.base_total), 64'(result.base_total));
                    check_field("symbol_total", 64'(oldest.symbol_total),
                                64'(result.symbol_total));
                end
            end
            if (item.valid && item.ready)
            begin
                apply_request(item.op, item.symbol);
            end
            outstanding = expected_tallies.size();
        end
    end

endmodule

FILE: sim/length_filtered_symbol_histogram_test.sv
`timescale 1ns / 100ps
// ============================================================================
// length_filtered_symbol_histogram_test
// Stimulus and verdict for the length-filtered symbol histogram.
// ============================================================================
// A short directed opening exercises the extreme symbol codes, every request
// kind and the unused op code. Random traffic of well-formed reads, queries
// and stray requests then runs under several length windows, including an
// empty window, a zero-length window and all-ones limits. Both channels idle
// at random except for one long stretch, and the receiver once stalls long
// enough for the block to back up its request channel. Checking is done by
// histogram_checker.
// ============================================================================
module length_filtered_symbol_histogram_test;
    import lfsh_pkg::*;

    localparam logic [OP_W-1:0]       OP_UNUSED       = 2'd3;
    localparam logic [CFG_DATA_W-1:0] LENGTH_ALL_ONES = '1;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 160;
    localparam int HOLD_OFF_CYCLES = 400;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    int stall_left   = 0;
    int cycle_count  = 0;
    int failures;
    int outstanding;
    int symbols_sent = 0;
    int ends_sent    = 0;
    int queries_sent = 0;
    int ignored_sent = 0;
    int windows_used = 0;
    int low_bound;

    lfsh_in_if  item_ch ();
    lfsh_out_if result_ch ();

    length_filtered_symbol_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    histogram_checker tally_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [SYMBOL_W-1:0] pick_symbol(input bit from_bases);
        logic [SYMBOL_W-1:0] code;
        if (!from_bases)
        begin
            code = SYMBOL_W'($urandom_range(127, 0));
        end
        else
        begin
            case ($urandom_range(3, 0))
                0: code = 7'h41;
                1: code = 7'h43;
                2: code = 7'h47;
                default: code = 7'h54;
            endcase
        end
        return code;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] symbol);
        while (gaps_on && $urandom_range(99, 0) < 38)
        begin
            item_ch.valid  = 1'b0;
            item_ch.op     = OP_W'($urandom_range(3, 0));
            item_ch.symbol = SYMBOL_W'($urandom_range(127, 0));
            @(negedge clk);
        end
        item_ch.valid  = 1'b1;
        item_ch.op     = op;
        item_ch.symbol = symbol;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        item_ch.valid = 1'b0;
        case (op)
            OP_SYMBOL: symbols_sent++;
            OP_END:    ends_sent++;
            OP_QUERY:  queries_sent++;
            default:   ignored_sent++;
        endcase
    endtask

    task automatic send_read(input int length);
        bit from_bases;
        from_bases = ($urandom_range(3, 0) != 0);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(99, 0) < 3)
            begin
                send_request(OP_QUERY, pick_symbol(from_bases));
            end
            send_request(OP_SYMBOL, pick_symbol(from_bases));
        end
        send_request(OP_END, SYMBOL_W'($urandom_range(127, 0)));
    endtask

    task automatic random_traffic(input int budget, input int longest);
        int stop_at;
        int roll;
        stop_at = symbols_sent + ends_sent + queries_sent + budget;
        while (symbols_sent + ends_sent + queries_sent < stop_at)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 72)
            begin
                send_read(($urandom_range(4, 0) == 0) ? $urandom_range(40, 0)
                                                      : $urandom_range(longest, 0));
            end
            else if (roll < 92)
            begin
                send_request(OP_QUERY, pick_symbol(1'($urandom_range(1, 0))));
            end
            else if (roll < 96)
            begin
                send_request(OP_UNUSED, SYMBOL_W'($urandom_range(127, 0)));
            end
            else
            begin
                send_request(OP_SYMBOL, SYMBOL_W'($urandom_range(127, 0)));
            end
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = CFG_DATA_W'({$urandom, $urandom});
    endtask

    // Registers may only change once every result is out and any queued
    // symbols have drained from the back end.
    task automatic set_length_window(input logic [CFG_DATA_W-1:0] shortest,
                                     input logic [CFG_DATA_W-1:0] longest);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_register(CFG_MIN_LEN, shortest);
        write_register(CFG_MAX_LEN, longest);
        windows_used++;
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready = 1'b0;
            end
            else
            begin
                result_ch.ready = !(gaps_on && $urandom_range(99, 0) < 38);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        item_ch.valid  = 1'b0;
        item_ch.op     = OP_SYMBOL;
        item_ch.symbol = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(OP_QUERY, 7'h00);
        send_request(OP_QUERY, 7'h7f);
        send_request(OP_SYMBOL, 7'h00);
        send_request(OP_SYMBOL, 7'h7f);
        send_request(OP_SYMBOL, 7'h55);
        send_request(OP_SYMBOL, 7'h2a);
        send_request(OP_SYMBOL, 7'h7f);
        send_request(OP_END, 7'h00);
        send_request(OP_QUERY, 7'h7f);
        send_request(OP_QUERY, 7'h55);
        send_request(OP_QUERY, 7'h2a);
        send_request(OP_UNUSED, 7'h7f);
        send_request(OP_UNUSED, 7'h00);
        send_request(OP_END, 7'h7f);
        send_request(OP_SYMBOL, 7'h41);
        send_request(OP_END, 7'h55);
        send_request(OP_QUERY, 7'h41);

        set_length_window(3, 6);
        random_traffic(300, 9);
        set_length_window(5, 4);
        random_traffic(100, 9);
        set_length_window(0, 0);
        random_traffic(80, 3);
        set_length_window(LENGTH_ALL_ONES, LENGTH_ALL_ONES);
        random_traffic(60, 9);
        low_bound = $urandom_range(8, 0);
        set_length_window(CFG_DATA_W'(low_bound),
                          CFG_DATA_W'(low_bound + int'($urandom_range(6, 0))));
        random_traffic(150, 12);
        set_length_window(0, LENGTH_ALL_ONES);
        gaps_on = 1'b0;
        random_traffic(150, 9);
        hold_request = 1'b1;
        repeat (40) send_request(OP_QUERY, pick_symbol(1'b1));
        gaps_on = 1'b1;
        random_traffic(150, 9);

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d symbols, %0d ends of read and %0d queries under %0d windows,",
                 symbols_sent, ends_sent, queries_sent, windows_used);
        $display("with %0d unused op codes, one long result stall and %0d mismatches.",
                 ignored_sent, failures);
        if (failures == 0 && outstanding == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: length_filtered_symbol_histogram.f
src/lfsh_pkg.sv
src/lfsh_if.sv
src/lfsh_front.sv
src/lfsh_queue.sv
src/lfsh_back.sv
src/length_filtered_symbol_histogram.sv
sim/histogram_checker.sv
sim/length_filtered_symbol_histogram_test.sv
